/* rtl/rgb_to_nv12_converter_assert.svh */
// Assertion macros for the RGB to NV12 converter.
// Needs a clock named clock and an active-high reset named reset in the including scope.
`ifndef RGB_TO_NV12_CONVERTER_ASSERT_SVH
`define RGB_TO_NV12_CONVERTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RNC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define RNC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/r2n_pkg.sv */
// Package for the RGB to NV12 converter: payload structs, register codes,
// conversion coefficients and the frame size clamp function. No dependencies.
`default_nettype none

package r2n_pkg;

   // Default storage limits.
   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_DATA_W-1:0]  RESET_FRAME_WIDTH  = 13'd640;
   localparam logic [CSR_DATA_W-1:0]  RESET_FRAME_HEIGHT = 13'd480;

   // Width of an effective frame size (holds up to 65535).
   localparam int SIZE_W = 16;

   // BT.601 full-range coefficients.
   localparam logic [7:0] Y_R = 8'd77;
   localparam logic [7:0] Y_G = 8'd150;
   localparam logic [7:0] Y_B = 8'd29;
   localparam logic signed [8:0] U_R = -9'sd43;
   localparam logic signed [8:0] U_G = -9'sd84;
   localparam logic signed [8:0] U_B = 9'sd127;
   localparam logic signed [8:0] V_R = 9'sd127;
   localparam logic signed [8:0] V_G = -9'sd106;
   localparam logic signed [8:0] V_B = -9'sd21;
   localparam logic signed [9:0] CHROMA_BIAS = 10'sd128;
   localparam logic signed [9:0] CHROMA_MAX  = 10'sd255;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [7:0]  luma;
      logic [23:0] luma_offset;
      logic        chroma_valid;
      logic [7:0]  chroma_u;
      logic [7:0]  chroma_v;
      logic [22:0] chroma_offset;
      logic        frame_end;
   } rsp_type;

   // Even size, at least 2, at most the even part of the limit.
   function automatic logic [SIZE_W-1:0] eff_size(input logic [CSR_DATA_W-1:0] size_val,
                                                  input int max_val);
      logic [SIZE_W-1:0] s;
      logic [SIZE_W-1:0] m;
      s = {{(SIZE_W-CSR_DATA_W){1'b0}}, size_val & 13'h1FFE};
      m = SIZE_W'(max_val) & ~(SIZE_W'(1));
      if (s < SIZE_W'(2)) s = SIZE_W'(2);
      if (m < SIZE_W'(2)) m = SIZE_W'(2);
      if (s > m) s = m;
      return s;
   endfunction

endpackage

`default_nettype wire

/* rtl/rgb_to_nv12_converter.sv */
// RGB888 to NV12 (full-range BT.601) streaming converter, top level.
// Depends on r2n_pkg and the macros in rgb_to_nv12_converter_assert.svh.
//
//   Channel  Direction  Handshake            Payload
//   req_     in         req_valid/req_stall  r2n_pkg::req_type (red, green, blue)
//   rsp_     out        rsp_valid/rsp_stall  r2n_pkg::rsp_type (luma, offsets, chroma)
//   csr_     in         csr_valid/csr_ready  csr_index, csr_data (frame sizes)
//
// One pixel per cycle while rsp_stall is low; each passes the stage and result registers.
// The line store read is issued at the input transfer and its data registered with the
// pixel, so the chroma math sits between the stage register and the result register.
// Reset is synchronous; it clears counters, held pixel and valid flags and restores the
// default sizes. The line store is not cleared. A stalled result holds the stage;
// req_stall rises only when the stage register is full and cannot move on.
`default_nettype none
`include "rgb_to_nv12_converter_assert.svh"

module rgb_to_nv12_converter #(
   parameter int MAX_WIDTH  = r2n_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = r2n_pkg::DEF_MAX_HEIGHT
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  r2n_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output r2n_pkg::rsp_type                   rsp_data,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [r2n_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  [r2n_pkg::CSR_DATA_W-1:0]     csr_data
);
   import r2n_pkg::*;

   localparam int CNT_W      = ($clog2(MAX_WIDTH) > 0) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W      = ($clog2(MAX_HEIGHT) > 0) ? $clog2(MAX_HEIGHT) : 1;
   localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
   localparam int LINE_AW    = ($clog2(LINE_DEPTH) > 0) ? $clog2(LINE_DEPTH) : 1;
   localparam int SUM_W      = 9;
   localparam int LINE_W     = 3 * SUM_W;

   localparam logic [SIZE_W-1:0] RESET_W_EFF = eff_size(RESET_FRAME_WIDTH, MAX_WIDTH);
   localparam logic [SIZE_W-1:0] RESET_H_EFF = eff_size(RESET_FRAME_HEIGHT, MAX_HEIGHT);

   // Stage register contents: the pixel plus everything its position implies.
   typedef struct packed {
      req_type          pixel;
      req_type          held;
      logic             col_odd;
      logic             row_odd;
      logic [CNT_W-1:0] col_half;
      logic [ROW_W-1:0] row_half;
      logic [23:0]      luma_pos;
      logic             frame_end;
   } stage_type;

   // Size registers, kept as last index and half width.
   logic [CNT_W-1:0] w_last_ff, w_last_in;
   logic [CNT_W-1:0] w_half_ff, w_half_in;
   logic [ROW_W-1:0] h_last_ff, h_last_in;
   logic [SIZE_W-1:0] csr_eff;

   // Position state.
   logic [CNT_W-1:0] column_count_ff, column_count_in;
   logic [ROW_W-1:0] row_count_ff, row_count_in;
   logic [23:0]      luma_position_ff, luma_position_in;
   req_type          held_pixel_ff, held_pixel_in;

   // Pipeline.
   logic             s1_valid_ff, s1_valid_in;
   stage_type        s1_ff, s1_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             req_xfer;
   logic             out_free;
   logic             s1_move;
   logic             row_end;
   logic             frame_end_now;
   logic [CNT_W-1:0] col_half_now;

   // Line store.
   logic [LINE_W-1:0] line_mem [LINE_DEPTH];
   logic [LINE_W-1:0] line_rd_ff;
   logic [LINE_AW-1:0] rd_addr;
   logic [LINE_AW-1:0] wr_addr;
   logic               line_we;
   logic [LINE_W-1:0]  line_wr_data;

   // Chroma and luma math.
   logic [SUM_W-1:0]   sum_r, sum_g, sum_b;
   logic [SUM_W:0]     quad_r, quad_g, quad_b;
   logic [7:0]         avg_r, avg_g, avg_b;
   logic signed [17:0] u_num, v_num;
   logic signed [9:0]  u_biased, v_biased;
   logic [7:0]         u_clamped, v_clamped;
   logic [15:0]        luma_sum;
   logic [23:0]        chroma_base;
   logic [23:0]        chroma_sum;

   // Handshake control.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Frame position of the incoming pixel.
   assign row_end       = column_count_ff >= w_last_ff;
   assign frame_end_now = row_end && (row_count_ff >= h_last_ff);
   assign col_half_now  = column_count_ff >> 1;
   assign rd_addr       = col_half_now[LINE_AW-1:0];

   // Size register writes.
   always_comb begin
      w_last_in = w_last_ff;
      w_half_in = w_half_ff;
      h_last_in = h_last_ff;
      csr_eff   = '0;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_FRAME_WIDTH: begin
               csr_eff   = eff_size(csr_data, MAX_WIDTH);
               w_last_in = CNT_W'(csr_eff - SIZE_W'(1));
               w_half_in = CNT_W'(csr_eff >> 1);
            end
            REG_FRAME_HEIGHT: begin
               csr_eff   = eff_size(csr_data, MAX_HEIGHT);
               h_last_in = ROW_W'(csr_eff - SIZE_W'(1));
            end
            default: begin
               csr_eff = '0;
            end
         endcase
      end
   end

   // Counter advance and stage load on an input transfer.
   always_comb begin
      column_count_in  = column_count_ff;
      row_count_in     = row_count_ff;
      luma_position_in = luma_position_ff;
      held_pixel_in    = held_pixel_ff;
      s1_in            = s1_ff;
      s1_valid_in      = s1_valid_ff && !s1_move;
      if (req_xfer) begin
         s1_valid_in     = 1'b1;
         s1_in.pixel     = req_data;
         s1_in.held      = held_pixel_ff;
         s1_in.col_odd   = column_count_ff[0];
         s1_in.row_odd   = row_count_ff[0];
         s1_in.col_half  = col_half_now;
         s1_in.row_half  = row_count_ff >> 1;
         s1_in.luma_pos  = luma_position_ff;
         s1_in.frame_end = frame_end_now;
         if (!column_count_ff[0]) begin
            held_pixel_in = req_data;
         end
         if (frame_end_now) begin
            column_count_in  = '0;
            row_count_in     = '0;
            luma_position_in = '0;
         end else begin
            luma_position_in = luma_position_ff + 24'd1;
            if (row_end) begin
               column_count_in = '0;
               row_count_in    = row_count_ff + ROW_W'(1);
            end else begin
               column_count_in = column_count_ff + CNT_W'(1);
            end
         end
      end
   end

   // Pair sums of the held even pixel and the current odd pixel.
   assign sum_r = SUM_W'(s1_ff.held.red)   + SUM_W'(s1_ff.pixel.red);
   assign sum_g = SUM_W'(s1_ff.held.green) + SUM_W'(s1_ff.pixel.green);
   assign sum_b = SUM_W'(s1_ff.held.blue)  + SUM_W'(s1_ff.pixel.blue);

   // Even rows store the pair sums for the row below.
   assign line_wr_data = {sum_r, sum_g, sum_b};
   assign wr_addr      = s1_ff.col_half[LINE_AW-1:0];
   assign line_we      = s1_move && s1_ff.col_odd && !s1_ff.row_odd;

   always_ff @(posedge clock) begin
      if (line_we) begin
         line_mem[wr_addr] <= line_wr_data;
      end
      if (req_xfer) begin
         line_rd_ff <= line_mem[rd_addr];
      end
   end

   // Truncated 2x2 averages.
   assign quad_r = (SUM_W+1)'(sum_r) + (SUM_W+1)'(line_rd_ff[3*SUM_W-1:2*SUM_W]);
   assign quad_g = (SUM_W+1)'(sum_g) + (SUM_W+1)'(line_rd_ff[2*SUM_W-1:SUM_W]);
   assign quad_b = (SUM_W+1)'(sum_b) + (SUM_W+1)'(line_rd_ff[SUM_W-1:0]);
   assign avg_r  = quad_r[SUM_W:2];
   assign avg_g  = quad_g[SUM_W:2];
   assign avg_b  = quad_b[SUM_W:2];

   // U and V numerators, floor shift, bias and clamp.
   assign u_num = 18'(U_R) * 18'($signed({1'b0, avg_r}))
                + 18'(U_G) * 18'($signed({1'b0, avg_g}))
                + 18'(U_B) * 18'($signed({1'b0, avg_b}));
   assign v_num = 18'(V_R) * 18'($signed({1'b0, avg_r}))
                + 18'(V_G) * 18'($signed({1'b0, avg_g}))
                + 18'(V_B) * 18'($signed({1'b0, avg_b}));
   assign u_biased = 10'(u_num >>> 8) + CHROMA_BIAS;
   assign v_biased = 10'(v_num >>> 8) + CHROMA_BIAS;

   always_comb begin
      if (u_biased < 0) begin
         u_clamped = 8'd0;
      end else if (u_biased > CHROMA_MAX) begin
         u_clamped = 8'd255;
      end else begin
         u_clamped = u_biased[7:0];
      end
      if (v_biased < 0) begin
         v_clamped = 8'd0;
      end else if (v_biased > CHROMA_MAX) begin
         v_clamped = 8'd255;
      end else begin
         v_clamped = v_biased[7:0];
      end
   end

   // Luma and the UV plane offset.
   assign luma_sum = 16'(Y_R) * 16'(s1_ff.pixel.red) + 16'(Y_G) * 16'(s1_ff.pixel.green)
                   + 16'(Y_B) * 16'(s1_ff.pixel.blue);
   assign chroma_base = 24'(s1_ff.row_half) * 24'(w_half_ff);
   assign chroma_sum  = chroma_base + 24'(s1_ff.col_half);

   // Result register.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s1_move) begin
         rsp_valid_in         = 1'b1;
         rsp_in.luma          = luma_sum[15:8];
         rsp_in.luma_offset   = s1_ff.luma_pos;
         rsp_in.chroma_valid  = 1'b0;
         rsp_in.chroma_u      = 8'd0;
         rsp_in.chroma_v      = 8'd0;
         rsp_in.chroma_offset = 23'd0;
         rsp_in.frame_end     = s1_ff.frame_end;
         if (s1_ff.col_odd && s1_ff.row_odd) begin
            rsp_in.chroma_valid  = 1'b1;
            rsp_in.chroma_u      = u_clamped;
            rsp_in.chroma_v      = v_clamped;
            rsp_in.chroma_offset = {chroma_sum[21:0], 1'b0};
         end
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff        <= CNT_W'(RESET_W_EFF - SIZE_W'(1));
         w_half_ff        <= CNT_W'(RESET_W_EFF >> 1);
         h_last_ff        <= ROW_W'(RESET_H_EFF - SIZE_W'(1));
         column_count_ff  <= '0;
         row_count_ff     <= '0;
         luma_position_ff <= '0;
         held_pixel_ff    <= '0;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         w_last_ff        <= w_last_in;
         w_half_ff        <= w_half_in;
         h_last_ff        <= h_last_in;
         column_count_ff  <= column_count_in;
         row_count_ff     <= row_count_in;
         luma_position_ff <= luma_position_in;
         held_pixel_ff    <= held_pixel_in;
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The input side only stalls behind a full stage register.
   `RNC_ASSERT_NOW(a_stall_needs_full_stage, req_stall, s1_valid_ff, "stall with empty stage")
   // A result without chroma carries zero chroma fields.
   `RNC_ASSERT_NOW(a_chroma_zero_when_absent, rsp_valid && !rsp_data.chroma_valid,
      rsp_data.chroma_u == 8'd0 && rsp_data.chroma_v == 8'd0 && rsp_data.chroma_offset == 23'd0,
      "chroma fields set without chroma_valid")
   // The last pixel of a frame returns all position state to the origin.
   `RNC_ASSERT_NEXT(a_frame_wrap, req_xfer && frame_end_now,
      column_count_ff == '0 && row_count_ff == '0 && luma_position_ff == 24'd0,
      "counters did not wrap at frame end")

endmodule

`default_nettype wire
